[rtl/core/rptg_pkg.sv]
// Shared types and constants for the ramped pulse train generator.
// Used by rptg_seq and ramped_pulse_train_generator_unit; depends on nothing.
`default_nettype none

package rptg_pkg;

   // Field widths of the timing registers and of the register index.
   localparam int TIME_W  = 16;
   localparam int COUNT_W = 8;
   localparam int CSR_INDEX_W = 4;

   // Default values of the top-level parameters.
   localparam int SYNC_WIDTH_DEFAULT      = 50;
   localparam int WIDTH_STEP_DEFAULT      = 50;
   localparam int INVERT_MODIFIED_DEFAULT = 0;

   // One input beat: one timing tick with the two switch levels.
   typedef struct packed {
      logic enable_switch;
      logic mode_switch;
   } req_type;

   // One result beat: output levels during that tick.
   typedef struct packed {
      logic pulse_level;
      logic sync_level;
      logic cycle_busy;
   } rsp_type;

   // One timing set (normal or modified).
   typedef struct packed {
      logic [TIME_W-1:0]  base_width;
      logic [TIME_W-1:0]  pulse_gap;
      logic [COUNT_W-1:0] pulse_count;
      logic [TIME_W-1:0]  block_gap;
   } timing_set_type;

   // Waveform phases.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SYNC,
      PH_PULSE,
      PH_GAP,
      PH_BLOCK
   } phase_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NORMAL_BASE_WIDTH,
      CSR_NORMAL_PULSE_GAP,
      CSR_NORMAL_PULSE_COUNT,
      CSR_NORMAL_BLOCK_GAP,
      CSR_MODIFIED_BASE_WIDTH,
      CSR_MODIFIED_PULSE_GAP,
      CSR_MODIFIED_PULSE_COUNT,
      CSR_MODIFIED_BLOCK_GAP
   } csr_index_type;

endpackage

`default_nettype wire

[rtl/core/rptg_seq.sv]
// Waveform sequencer: phase state machine, phase down-counter and pulse index.
// Depends on rptg_pkg for the beat, timing set and phase types.
`default_nettype none

module rptg_seq #(
   parameter int SYNC_WIDTH      = rptg_pkg::SYNC_WIDTH_DEFAULT,
   parameter int WIDTH_STEP      = rptg_pkg::WIDTH_STEP_DEFAULT,
   parameter int INVERT_MODIFIED = rptg_pkg::INVERT_MODIFIED_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire rptg_pkg::req_type        req,
   input  wire rptg_pkg::timing_set_type normal_set,
   input  wire rptg_pkg::timing_set_type modified_set,
   output rptg_pkg::rsp_type             rsp
);

   // Longest phase: the last pulse of a full block, or the sync phase.
   localparam int MAX_PULSE = (2 ** rptg_pkg::TIME_W - 1)
                            + WIDTH_STEP * (2 ** rptg_pkg::COUNT_W - 2);
   localparam int MAX_LEN   = (MAX_PULSE > SYNC_WIDTH) ? MAX_PULSE : SYNC_WIDTH;
   localparam int CNT_W     = $clog2(MAX_LEN + 1);

   typedef logic [CNT_W-1:0] cnt_type;

   localparam cnt_type SYNC_LEN = CNT_W'(SYNC_WIDTH);
   localparam cnt_type STEP_LEN = CNT_W'(WIDTH_STEP);

   rptg_pkg::phase_type      phase_ff, phase_in;
   cnt_type                  remain_ff, remain_in;
   cnt_type                  plen_ff, plen_in;
   logic [rptg_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic                     mod_ff, mod_in;
   logic                     a_ff, a_in;
   rptg_pkg::timing_set_type set_ff, set_in;

   logic                     rest_lvl;
   logic [rptg_pkg::COUNT_W:0] next_idx;
   logic                     more_pulses;
   cnt_type                  next_len;
   cnt_type                  gap_len;
   cnt_type                  block_len;

   // Rest level of output A for the latched set.
   assign rest_lvl = (INVERT_MODIFIED != 0) && mod_ff;

   // Values that the following pulse would take.
   assign next_idx    = {1'b0, idx_ff} + 1'b1;
   assign more_pulses = next_idx < {1'b0, set_ff.pulse_count};
   assign next_len    = plen_ff + STEP_LEN;
   assign gap_len     = CNT_W'(set_ff.pulse_gap);
   assign block_len   = CNT_W'(set_ff.block_gap);

   // State register, updated once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rptg_pkg::PH_IDLE;
         remain_ff <= '0;
         plen_ff   <= '0;
         idx_ff    <= '0;
         mod_ff    <= 1'b0;
         a_ff      <= 1'b0;
         set_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         plen_ff   <= plen_in;
         idx_ff    <= idx_in;
         mod_ff    <= mod_in;
         a_ff      <= a_in;
         set_ff    <= set_in;
      end
   end

   // Next state and result for one tick. Zero-length phases collapse within
   // the tick: a zero pulse falls into its gap, a zero gap into the next
   // pulse, and when both pulse and gap are zero the rest of the block
   // collapses into the block gap.
   always_comb begin
      logic go_next;
      logic go_block;
      go_next   = 1'b0;
      go_block  = 1'b0;
      phase_in  = phase_ff;
      remain_in = remain_ff;
      plen_in   = plen_ff;
      idx_in    = idx_ff;
      mod_in    = mod_ff;
      a_in      = a_ff;
      set_in    = set_ff;

      // Leave a phase whose time has run out.
      if (phase_ff != rptg_pkg::PH_IDLE && remain_ff == '0) begin
         case (phase_ff)
            rptg_pkg::PH_SYNC: begin
               if (set_ff.pulse_count == '0) begin
                  go_block = 1'b1;
               end else if (plen_ff != '0) begin
                  phase_in  = rptg_pkg::PH_PULSE;
                  remain_in = plen_ff;
                  a_in      = ~rest_lvl;
               end else begin
                  a_in = rest_lvl;
                  if (gap_len != '0) begin
                     phase_in  = rptg_pkg::PH_GAP;
                     remain_in = gap_len;
                  end else begin
                     go_next = 1'b1;
                  end
               end
            end
            rptg_pkg::PH_PULSE: begin
               a_in = rest_lvl;
               if (gap_len != '0) begin
                  phase_in  = rptg_pkg::PH_GAP;
                  remain_in = gap_len;
               end else begin
                  go_next = 1'b1;
               end
            end
            rptg_pkg::PH_GAP: begin
               go_next = 1'b1;
            end
            default: begin
               phase_in = rptg_pkg::PH_IDLE;
            end
         endcase
      end

      // Move on to the following pulse, or end the block.
      if (go_next) begin
         if (!more_pulses) begin
            go_block = 1'b1;
         end else begin
            idx_in  = next_idx[rptg_pkg::COUNT_W-1:0];
            plen_in = next_len;
            if (next_len != '0) begin
               phase_in  = rptg_pkg::PH_PULSE;
               remain_in = next_len;
               a_in      = ~rest_lvl;
            end else begin
               a_in = rest_lvl;
               if (gap_len != '0) begin
                  phase_in  = rptg_pkg::PH_GAP;
                  remain_in = gap_len;
               end else begin
                  go_block = 1'b1;
               end
            end
         end
      end

      // Block gap, skipped when zero.
      if (go_block) begin
         if (block_len != '0) begin
            phase_in  = rptg_pkg::PH_BLOCK;
            remain_in = block_len;
         end else begin
            phase_in = rptg_pkg::PH_IDLE;
         end
      end

      // Start a new cycle from idle, latching the chosen set.
      if (phase_in == rptg_pkg::PH_IDLE && !req.enable_switch) begin
         mod_in    = req.mode_switch;
         set_in    = req.mode_switch ? modified_set : normal_set;
         idx_in    = '0;
         plen_in   = CNT_W'(set_in.base_width);
         phase_in  = rptg_pkg::PH_SYNC;
         remain_in = SYNC_LEN;
      end

      // Levels during this tick.
      rsp.pulse_level = a_in;
      rsp.sync_level  = (phase_in == rptg_pkg::PH_SYNC);
      rsp.cycle_busy  = (phase_in != rptg_pkg::PH_IDLE);

      // Count this tick against the current phase.
      if (phase_in != rptg_pkg::PH_IDLE) begin
         remain_in = remain_in - 1'b1;
      end
   end

   // A start from idle always lands in the sync phase.
   a_start_sync: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == rptg_pkg::PH_IDLE && !req.enable_switch
      |=> phase_ff == rptg_pkg::PH_SYNC)
      else $error("cycle start did not enter sync phase");

   // A phase with time left does not change on a tick.
   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff != rptg_pkg::PH_IDLE && remain_ff != '0
      |=> phase_ff == $past(phase_ff))
      else $error("phase left before its time ran out");

   // Output A is active during a pulse and at rest during a gap.
   a_pulse_level: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rptg_pkg::PH_PULSE) |-> (a_ff == ~rest_lvl))
      else $error("output A not active during pulse");

   a_gap_level: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rptg_pkg::PH_GAP) |-> (a_ff == rest_lvl))
      else $error("output A not at rest during gap");

   // The pulse index stays inside the latched pulse count.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rptg_pkg::PH_PULSE || phase_ff == rptg_pkg::PH_GAP)
      |-> (idx_ff < set_ff.pulse_count))
      else $error("pulse index beyond pulse count");

endmodule

`default_nettype wire

[rtl/core/ramped_pulse_train_generator_unit.sv]
// Ramped pulse train generator: configuration registers, beat handshake and
// result register. Depends on rptg_pkg and rptg_seq.
//
// Usage:
// - Each req_ beat is one timing tick carrying the two switch levels. Each
//   accepted beat yields exactly one rsp_ beat with the levels of output A,
//   output B (sync) and the busy flag during that tick.
// - A beat's result is registered and shown on rsp_valid in the cycle after
//   it is accepted. One beat can be accepted in every cycle while req_stall
//   is low; the sequencer works out a whole tick, including any run of
//   zero-length phases, in one pass between the state and result registers.
// - The result register is a single stage. While it is full and rsp_stall
//   is high, req_stall is high and the sequencer state holds.
// - The csr_ port writes one of the eight timing registers per cycle; an
//   index beyond the list is ignored. A set is latched at the start of each
//   waveform cycle, so writes take effect from the next cycle start.
// - Reset clears all timing registers, puts the sequencer in idle with A
//   low, and empties the result register. There is no clearing pass.
`default_nettype none

module ramped_pulse_train_generator_unit #(
   parameter int SYNC_WIDTH      = rptg_pkg::SYNC_WIDTH_DEFAULT,
   parameter int WIDTH_STEP      = rptg_pkg::WIDTH_STEP_DEFAULT,
   parameter int INVERT_MODIFIED = rptg_pkg::INVERT_MODIFIED_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire rptg_pkg::req_type                req_payload,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output rptg_pkg::rsp_type                     rsp_payload,

   input  wire logic                             csr_we,
   input  wire logic [rptg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rptg_pkg::TIME_W-1:0]      csr_wdata
);

   rptg_pkg::timing_set_type normal_set_ff;
   rptg_pkg::timing_set_type modified_set_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rptg_pkg::rsp_type rsp_ff;
   rptg_pkg::rsp_type seq_rsp;
   logic              step;

   // Timing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_set_ff   <= '0;
         modified_set_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rptg_pkg::CSR_NORMAL_BASE_WIDTH: begin
               normal_set_ff.base_width <= csr_wdata;
            end
            rptg_pkg::CSR_NORMAL_PULSE_GAP: begin
               normal_set_ff.pulse_gap <= csr_wdata;
            end
            rptg_pkg::CSR_NORMAL_PULSE_COUNT: begin
               normal_set_ff.pulse_count <= csr_wdata[rptg_pkg::COUNT_W-1:0];
            end
            rptg_pkg::CSR_NORMAL_BLOCK_GAP: begin
               normal_set_ff.block_gap <= csr_wdata;
            end
            rptg_pkg::CSR_MODIFIED_BASE_WIDTH: begin
               modified_set_ff.base_width <= csr_wdata;
            end
            rptg_pkg::CSR_MODIFIED_PULSE_GAP: begin
               modified_set_ff.pulse_gap <= csr_wdata;
            end
            rptg_pkg::CSR_MODIFIED_PULSE_COUNT: begin
               modified_set_ff.pulse_count <= csr_wdata[rptg_pkg::COUNT_W-1:0];
            end
            rptg_pkg::CSR_MODIFIED_BLOCK_GAP: begin
               modified_set_ff.block_gap <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // A beat is taken whenever the result register is empty or draining.
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign step         = req_valid & ~req_stall;
   assign rsp_valid_in = step | (rsp_valid_ff & rsp_stall);

   rptg_seq #(
      .SYNC_WIDTH      (SYNC_WIDTH),
      .WIDTH_STEP      (WIDTH_STEP),
      .INVERT_MODIFIED (INVERT_MODIFIED)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .req          (req_payload),
      .normal_set   (normal_set_ff),
      .modified_set (modified_set_ff),
      .rsp          (seq_rsp)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= seq_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
